// ----- hw/rtl/lru_key_value_cache_defines.svh -----
// Assertion macros for the LRU key/value cache.
// Both expect signals named clock and reset in the enclosing scope.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication.
`define LKV_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/lkv_pkg.sv -----
`timescale 1ns / 1ps

package lkv_pkg;

   localparam int CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef struct packed {
      logic load_req;
      logic lookup;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic rsp_pending;
   } status_type;

endpackage

// ----- hw/rtl/lkv_ram.sv -----
`timescale 1ns / 1ps

module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lkv_datapath.sv -----
`timescale 1ns / 1ps
`include "lru_key_value_cache_defines.svh"

module lkv_datapath #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int UW = $clog2(ENTRIES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkv_pkg::cmd_type              cmd,
   output lkv_pkg::status_type           status,
   input  logic                          req_operation,
   input  logic [KEY_BITS-1:0]           req_key,
   input  logic [VALUE_BITS-1:0]         req_new_value,
   input  logic                          csr_write_enable,
   input  logic [lkv_pkg::CAP_BITS-1:0]  csr_write_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [VALUE_BITS-1:0]         rsp_read_value,
   output logic                          rsp_evicted
);

   localparam int CW = (lkv_pkg::CAP_BITS > UW) ? lkv_pkg::CAP_BITS : UW;

   // captured request
   logic                  op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   // cache state
   logic [KEY_BITS-1:0]          key_store_ff [ENTRIES];
   logic [ENTRIES-1:0]           valid_ff, valid_in;
   logic [IW-1:0]                rank_ff [ENTRIES];
   logic [IW-1:0]                rank_in [ENTRIES];
   logic [UW-1:0]                used_ff, used_in;
   logic [lkv_pkg::CAP_BITS-1:0] cap_ff;

   // lookup results
   logic          hit_ff, evict_ff, write_ff;
   logic [IW-1:0] hit_idx_ff, hit_rank_ff, slot_ff;

   // output word
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_evicted_ff;
   logic [VALUE_BITS-1:0] rsp_read_value_ff;

   logic [ENTRIES-1:0]    match;
   logic [IW-1:0]         hit_idx, hit_rank, lru_idx, free_idx, slot;
   logic [UW-1:0]         used_minus_one;
   logic [IW-1:0]         lru_rank;
   logic [CW-1:0]         cap_ext, cap_eff;
   logic                  lookup_hit, full, lookup_write, lookup_evict;
   logic [VALUE_BITS-1:0] ram_rdata;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_operation;
         key_ff   <= req_key;
         value_ff <= req_new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkv_pkg::CAP_RESET;
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   // parallel compare, LRU and free-slot selection
   assign used_minus_one = used_ff - UW'(1);
   assign lru_rank       = used_minus_one[IW-1:0];

   always_comb begin
      match    = '0;
      hit_idx  = '0;
      hit_rank = '0;
      lru_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_store_ff[i] == key_ff);
         if (match[i]) begin
            hit_idx  = hit_idx | IW'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
         if (valid_ff[i] && (rank_ff[i] == lru_rank)) begin
            lru_idx = lru_idx | IW'(i);
         end
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   // capacity 0 acts as 1, above ENTRIES acts as ENTRIES
   assign cap_ext = CW'(cap_ff);
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CW'(1);
      end else if (cap_ext > CW'(ENTRIES)) begin
         cap_eff = CW'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign lookup_hit   = |match;
   assign full         = CW'(used_ff) >= cap_eff;
   assign lookup_write = (op_ff == lkv_pkg::OP_INSERT) && !lookup_hit;
   assign lookup_evict = lookup_write && full;
   assign slot         = lookup_evict ? lru_idx : free_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         evict_ff <= 1'b0;
         write_ff <= 1'b0;
      end else if (cmd.lookup) begin
         hit_ff   <= lookup_hit;
         evict_ff <= lookup_evict;
         write_ff <= lookup_write;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_idx_ff  <= hit_idx;
         hit_rank_ff <= hit_rank;
         slot_ff     <= slot;
      end
   end

   lkv_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && write_ff),
      .wr_addr (slot_ff),
      .wr_data (value_ff),
      .rd_en   (cmd.lookup),
      .rd_addr (hit_idx),
      .rd_data (ram_rdata)
   );

   // recency and occupancy update
   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cmd.commit) begin
         if (hit_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (IW'(i) == hit_idx_ff) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + IW'(1);
               end
            end
         end else if (write_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (IW'(i) == slot_ff) begin
                  valid_in[i] = 1'b1;
                  rank_in[i]  = '0;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + IW'(1);
               end
            end
            if (!evict_ff) begin
               used_in = used_ff + UW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && write_ff) begin
         key_store_ff[slot_ff] <= key_ff;
      end
   end

   // output register
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff        <= hit_ff;
         rsp_read_value_ff <= hit_ff ? ram_rdata : '0;
         rsp_evicted_ff    <= evict_ff;
      end
   end

   assign status.rsp_pending = rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_evicted        = rsp_evicted_ff;

   `LKV_ASSERT(a_used_matches_valid, 1'b1, $countones(valid_ff) == int'(used_ff), "count mismatch")
   `LKV_ASSERT(a_evict_needs_entry, cmd.commit && evict_ff, used_ff != '0, "evict from empty")
   `LKV_ASSERT_NEXT(a_write_sets_valid, cmd.commit && write_ff, valid_ff[$past(slot_ff)], "slot not valid")

endmodule

// ----- hw/rtl/lkv_ctrl.sv -----
`timescale 1ns / 1ps
`include "lru_key_value_cache_defines.svh"

module lkv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                rsp_ready,
   input  lkv_pkg::status_type status,
   output lkv_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       out_free, accept;

   assign out_free  = !status.rsp_pending || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_COMMIT) && out_free);
   assign accept    = req_valid && req_ready;

   assign cmd.load_req = accept;
   assign cmd.lookup   = state_ff == S_LOOKUP;
   assign cmd.commit   = (state_ff == S_COMMIT) && out_free;

   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            state_in = accept ? S_LOOKUP : S_IDLE;
         end
         S_LOOKUP: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               state_in = accept ? S_LOOKUP : S_IDLE;
            end else begin
               state_in = S_COMMIT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LKV_ASSERT_NEXT(a_lookup_then_commit, state_ff == S_LOOKUP, state_ff == S_COMMIT, "lost lookup")

endmodule

// ----- hw/rtl/lru_key_value_cache.sv -----
// Fully associative LRU key/value cache.
// A req word does its compare/value-RAM read in LOOKUP, then its update in COMMIT, which
// waits out an rsp stall and registers rsp_valid; the next word can be accepted in COMMIT.
// Reset clears valid flags, recency ranks and entry count, and sets capacity to 16;
// stored keys and values are not cleared.
`timescale 1ns / 1ps

module lru_key_value_cache #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [KEY_BITS-1:0]          req_key,
   input  logic [VALUE_BITS-1:0]        req_new_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [VALUE_BITS-1:0]        rsp_read_value,
   output logic                         rsp_evicted,
   input  logic                         csr_write_enable,
   input  logic [lkv_pkg::CAP_BITS-1:0] csr_write_data
);

   lkv_pkg::cmd_type    cmd;
   lkv_pkg::status_type status;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lkv_datapath #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_new_value    (req_new_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted)
   );

endmodule
